>>> sv/ps2md_pkg.sv
`default_nettype none
package ps2md_pkg;

    localparam int RUN_MAX = 5;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);

    // device modes
    localparam logic [2:0] MODE_STREAM = 3'd0;
    localparam logic [2:0] MODE_REMOTE = 3'd1;
    localparam logic [2:0] MODE_WRAP   = 3'd2;
    localparam logic [2:0] MODE_RESET  = 3'd3;
    localparam logic [2:0] MODE_ARG    = 3'd4;

    // host commands
    localparam logic [7:0] CMD_RESET      = 8'hFF;
    localparam logic [7:0] CMD_RESEND     = 8'hFE;
    localparam logic [7:0] CMD_DISABLE    = 8'hF5;
    localparam logic [7:0] CMD_ENABLE     = 8'hF4;
    localparam logic [7:0] CMD_SET_RATE   = 8'hF3;
    localparam logic [7:0] CMD_GET_ID     = 8'hF2;
    localparam logic [7:0] CMD_REMOTE     = 8'hF0;
    localparam logic [7:0] CMD_WRAP       = 8'hEE;
    localparam logic [7:0] CMD_RESET_WRAP = 8'hEC;
    localparam logic [7:0] CMD_READ       = 8'hEB;
    localparam logic [7:0] CMD_STREAM     = 8'hEA;
    localparam logic [7:0] CMD_STATUS     = 8'hE9;
    localparam logic [7:0] CMD_SET_RES    = 8'hE8;

    // reply bytes
    localparam logic [7:0] RSP_ACK      = 8'hFA;
    localparam logic [7:0] RSP_BAT      = 8'hAA;
    localparam logic [7:0] RSP_ID_PLAIN = 8'h00;
    localparam logic [7:0] RSP_ID_WHEEL = 8'h04;

    localparam logic [7:0] KNOCK_HI       = 8'd200;
    localparam logic [7:0] KNOCK_LO       = 8'd80;
    localparam logic [7:0] MOVE_REPORT_ID = 8'h02;
    localparam logic [7:0] PKT_HEAD       = 8'h08;
    localparam logic [7:0] RATE_RESET     = 8'd100;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        host_byte;
        logic [7:0]        report_id;
        logic [7:0]        button_bits;
        logic signed [15:0] raw_dx;
        logic signed [15:0] raw_dy;
    } item_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
    } run_t;

endpackage
`default_nettype wire

>>> sv/ps2md_core.sv
`default_nettype none
module ps2md_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          go,
    input  wire logic          emu_dis,
    input  wire ps2md_pkg::item_t item,
    output ps2md_pkg::run_t    run
);

    logic [2:0]      mode_reg, mode_next;
    logic [2:0]      saved_mode_reg, saved_mode_next;
    logic [7:0]      last_cmd_reg, last_cmd_next;
    logic            report_en_reg, report_en_next;
    logic            wheel_reg, wheel_next;
    logic [1:0]      knock_reg, knock_next;
    logic [7:0]      rate_reg, rate_next;
    logic [7:0]      res_reg, res_next;
    logic [2:0][7:0] pkt_reg, pkt_next;

    logic [8:0]  x_c, y_c;
    logic [7:0]  head;
    logic [7:0]  d;
    logic [2:0][7:0] new_pkt;

    function automatic logic [8:0] clamp9(input logic signed [16:0] v);
        if (v > 17'sd255) begin
            return 9'h0FF;
        end else if (v < -17'sd255) begin
            return 9'h101;
        end
        return v[8:0];
    endfunction

    // Y flips sign; 17 bits hold +32768 before the clamp
    always_comb begin
        x_c  = clamp9({item.raw_dx[15], item.raw_dx});
        y_c  = clamp9(17'sd0 - {item.raw_dy[15], item.raw_dy});
        head = ps2md_pkg::PKT_HEAD | {6'd0, item.button_bits[1:0]}
             | {2'd0, y_c[8], x_c[8], 4'd0};
        new_pkt = {y_c[7:0], x_c[7:0], head};
    end

    assign d = item.host_byte;

    always_comb begin
        mode_next       = mode_reg;
        saved_mode_next = saved_mode_reg;
        last_cmd_next   = last_cmd_reg;
        report_en_next  = report_en_reg;
        wheel_next      = wheel_reg;
        knock_next      = knock_reg;
        rate_next       = rate_reg;
        res_next        = res_reg;
        pkt_next        = pkt_reg;
        run             = '0;

        if (item.req_type) begin
            if (mode_reg != ps2md_pkg::MODE_RESET
                    && item.report_id == ps2md_pkg::MOVE_REPORT_ID) begin
                pkt_next     = new_pkt;
                run.bytes[0] = new_pkt[0];
                run.bytes[1] = new_pkt[1];
                run.bytes[2] = new_pkt[2];
                run.cnt      = wheel_reg ? ps2md_pkg::CNT_W'(4) : ps2md_pkg::CNT_W'(3);
            end
        end else if (!emu_dis) begin
            unique case (mode_reg)
                ps2md_pkg::MODE_RESET: begin
                    run.bytes[0] = ps2md_pkg::RSP_ACK;
                    run.bytes[1] = ps2md_pkg::RSP_BAT;
                    run.bytes[2] = ps2md_pkg::RSP_ID_PLAIN;
                    run.cnt      = ps2md_pkg::CNT_W'(3);
                    mode_next    = ps2md_pkg::MODE_STREAM;
                    wheel_next   = 1'b0;
                end
                ps2md_pkg::MODE_ARG: begin
                    if (last_cmd_reg == ps2md_pkg::CMD_SET_RATE) begin
                        if (knock_reg == 2'd0 && d == ps2md_pkg::KNOCK_HI) begin
                            knock_next = 2'd1;
                        end else if (knock_reg == 2'd1 && d == ps2md_pkg::KNOCK_HI) begin
                            knock_next = 2'd2;
                        end else if (knock_reg == 2'd2 && d == ps2md_pkg::KNOCK_LO) begin
                            knock_next = 2'd3;
                            wheel_next = 1'b1;
                        end
                        rate_next = d;
                    end else if (last_cmd_reg == ps2md_pkg::CMD_SET_RES) begin
                        res_next = d;
                    end
                    mode_next    = saved_mode_reg;
                    run.bytes[0] = ps2md_pkg::RSP_ACK;
                    run.cnt      = ps2md_pkg::CNT_W'(1);
                end
                ps2md_pkg::MODE_STREAM, ps2md_pkg::MODE_REMOTE: begin
                    last_cmd_next = d;
                    run.bytes[0]  = ps2md_pkg::RSP_ACK;
                    run.cnt       = ps2md_pkg::CNT_W'(1);
                    unique case (d)
                        ps2md_pkg::CMD_RESET: begin
                            mode_next    = ps2md_pkg::MODE_STREAM;
                            run.bytes[1] = ps2md_pkg::RSP_BAT;
                            run.bytes[2] = ps2md_pkg::RSP_ID_PLAIN;
                            run.cnt      = ps2md_pkg::CNT_W'(3);
                            wheel_next   = 1'b0;
                            knock_next   = 2'd0;
                        end
                        ps2md_pkg::CMD_READ: begin
                            run.bytes[1] = pkt_reg[0];
                            run.bytes[2] = pkt_reg[1];
                            run.bytes[3] = pkt_reg[2];
                            run.cnt      = wheel_reg ? ps2md_pkg::CNT_W'(5)
                                                     : ps2md_pkg::CNT_W'(4);
                        end
                        ps2md_pkg::CMD_RESEND: begin
                            run.bytes[0] = pkt_reg[0];
                            run.bytes[1] = pkt_reg[1];
                            run.bytes[2] = pkt_reg[2];
                            run.cnt      = wheel_reg ? ps2md_pkg::CNT_W'(4)
                                                     : ps2md_pkg::CNT_W'(3);
                        end
                        ps2md_pkg::CMD_REMOTE: begin
                            mode_next = ps2md_pkg::MODE_REMOTE;
                        end
                        ps2md_pkg::CMD_DISABLE: begin
                            report_en_next = 1'b0;
                        end
                        ps2md_pkg::CMD_STREAM, ps2md_pkg::CMD_ENABLE: begin
                            report_en_next = 1'b1;
                            mode_next      = ps2md_pkg::MODE_STREAM;
                        end
                        ps2md_pkg::CMD_SET_RATE, ps2md_pkg::CMD_SET_RES: begin
                            saved_mode_next = mode_reg;
                            mode_next       = ps2md_pkg::MODE_ARG;
                        end
                        ps2md_pkg::CMD_GET_ID: begin
                            run.bytes[1] = wheel_reg ? ps2md_pkg::RSP_ID_WHEEL
                                                     : ps2md_pkg::RSP_ID_PLAIN;
                            run.cnt      = ps2md_pkg::CNT_W'(2);
                        end
                        ps2md_pkg::CMD_WRAP: begin
                            mode_next = ps2md_pkg::MODE_WRAP;
                        end
                        ps2md_pkg::CMD_STATUS: begin
                            run.bytes[1] = {1'b0, mode_reg == ps2md_pkg::MODE_REMOTE,
                                            report_en_reg, 5'd0};
                            run.bytes[2] = res_reg;
                            run.bytes[3] = rate_reg;
                            run.cnt      = ps2md_pkg::CNT_W'(4);
                        end
                        default: begin
                        end
                    endcase
                end
                ps2md_pkg::MODE_WRAP: begin
                    run.cnt = ps2md_pkg::CNT_W'(1);
                    if (d == ps2md_pkg::CMD_RESET || d == ps2md_pkg::CMD_RESET_WRAP) begin
                        mode_next    = ps2md_pkg::MODE_RESET;
                        run.bytes[0] = ps2md_pkg::RSP_ACK;
                    end else begin
                        run.bytes[0] = d;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ps2md_pkg::MODE_STREAM;
            saved_mode_reg <= ps2md_pkg::MODE_STREAM;
            last_cmd_reg   <= '0;
            report_en_reg  <= 1'b1;
            wheel_reg      <= 1'b0;
            knock_reg      <= '0;
            rate_reg       <= ps2md_pkg::RATE_RESET;
            res_reg        <= '0;
            pkt_reg        <= {8'h00, 8'h00, ps2md_pkg::PKT_HEAD};
        end else if (go) begin
            mode_reg       <= mode_next;
            saved_mode_reg <= saved_mode_next;
            last_cmd_reg   <= last_cmd_next;
            report_en_reg  <= report_en_next;
            wheel_reg      <= wheel_next;
            knock_reg      <= knock_next;
            rate_reg       <= rate_next;
            res_reg        <= res_next;
            pkt_reg        <= pkt_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/ps2md_tx.sv
`default_nettype none
module ps2md_tx (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire ps2md_pkg::run_t run,
    output logic            free,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [ps2md_pkg::RUN_MAX-1:0][7:0] bytes_reg;
    logic [ps2md_pkg::CNT_W-1:0]        cnt_reg;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == ps2md_pkg::CNT_W'(1));
    // a new run may load on the edge that takes the last beat
    assign free     = !m_tvalid || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= run.bytes;
        end else if (m_tvalid && m_tready) begin
            bytes_reg <= {8'h00, bytes_reg[ps2md_pkg::RUN_MAX-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= run.cnt;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - ps2md_pkg::CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

>>> sv/ps2_mouse_device_emulator.sv
// Flow: a beat taken on s_ is registered, then decoded once the reply register is free;
// its first reply byte is offered on m_ in the cycle after that decode.
// Throughput: one input beat per cycle while m_tready is high and each beat yields at most
// one byte; an input of n bytes (n up to 5) holds the reply register until all are taken.
// Reset: synchronous, active low; mode stream, reporting on, rate 100, stored packet 08 00 00.
`default_nettype none
module ps2_mouse_device_emulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // host_byte[7:0], report_id[15:8], button_bits[23:16], raw_dx[39:24], raw_dy[55:40]
    input  wire logic [55:0] s_tdata,
    // req_type[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    ps2md_pkg::item_t item_reg;
    logic             in_valid_reg;
    logic             emu_dis_reg;
    logic             tx_free;
    logic             go;
    ps2md_pkg::run_t  run;

    assign go        = in_valid_reg && tx_free;
    assign s_tready  = !in_valid_reg || tx_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.req_type    <= s_tuser[0];
            item_reg.host_byte   <= s_tdata[7:0];
            item_reg.report_id   <= s_tdata[15:8];
            item_reg.button_bits <= s_tdata[23:16];
            item_reg.raw_dx      <= s_tdata[39:24];
            item_reg.raw_dy      <= s_tdata[55:40];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            emu_dis_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid) begin
                emu_dis_reg <= cfg_data;
            end
        end
    end

    ps2md_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .emu_dis (emu_dis_reg),
        .item    (item_reg),
        .run     (run)
    );

    ps2md_tx u_tx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (go && run.cnt != '0),
        .run      (run),
        .free     (tx_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
